@@ design/slp_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter package
// Shared constants, types and sizes for the servo pulse-width slew limiter.
// ----------------------------------------------------------------------------
package slp_pkg;

    // Channel count and the index width that addresses the channel registers.
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Only the low eight channels have a bit in the settle mask.
    localparam int MASK_W   = 8;
    localparam int MASK_N   = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;
    localparam logic [MASK_W-1:0] MASK_RESET = 8'd7;

    // Field widths of the item and the result.
    localparam int MODE_W   = 2;
    localparam int CHAN_W   = 3;
    localparam int ANGLE_W  = 11;
    localparam int WIDTH_W  = 11;

    // Pulse width range in timer ticks.
    localparam int W_MIN    = 250;
    localparam int W_MAX    = 1250;

    // angle * 25 / 9 is done as angle * (25 * 29128) >> 18, exact for angles up to 1023.
    localparam int ANG_RECIP = 25 * 29128;
    localparam int ANG_SHIFT = 18;
    localparam int ANG_MAG_W = ANGLE_W - 1;
    localparam int PROD_W    = 30;
    localparam int QUOT_W    = PROD_W - ANG_SHIFT;

    // Slew thresholds and step sizes.
    localparam int GAP_BIG   = 45;
    localparam int GAP_MID   = 25;
    localparam int STEP_BIG  = 10;
    localparam int STEP_MID  = 5;
    localparam int STEP_MIN  = 1;
    localparam int STEP_W    = 4;

    // Item operations; code 3 carries no meaning and changes nothing.
    typedef enum logic [MODE_W-1:0] {
        MODE_INIT = 2'd0,
        MODE_SET  = 2'd1,
        MODE_STEP = 2'd2
    } t_mode;

    typedef logic [WIDTH_W-1:0] t_width;

endpackage

@@ design/slp_item_if.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter item channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface slp_item_if;
    logic                                valid;
    logic                                ready;
    logic [slp_pkg::MODE_W-1:0]          mode;
    logic [slp_pkg::CHAN_W-1:0]          channel;
    logic signed [slp_pkg::ANGLE_W-1:0]  angle_deg;

    modport source (output valid, mode, channel, angle_deg, input ready);
    modport sink   (input valid, mode, channel, angle_deg, output ready);
endinterface

@@ design/slp_result_if.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface slp_result_if;
    logic                         valid;
    logic                         ready;
    logic [slp_pkg::WIDTH_W-1:0]  width_now;
    logic [slp_pkg::WIDTH_W-1:0]  width_goal;
    logic                         all_settled;
    logic                         angle_rejected;

    modport source (output valid, width_now, width_goal, all_settled, angle_rejected,
                    input ready);
    modport sink   (input valid, width_now, width_goal, all_settled, angle_rejected,
                    output ready);
endinterface

@@ design/slp_angle_map.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter angle map
// Maps a non-negative angle in degrees to a clamped pulse width.
// ----------------------------------------------------------------------------
module slp_angle_map (
    input  logic [slp_pkg::ANG_MAG_W-1:0] i_angle,
    output slp_pkg::t_width               o_width
);
    import slp_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // Divide angle * 25 by 9 through a constant reciprocal multiply.
    assign prod = PROD_W'(i_angle) * PROD_W'(ANG_RECIP);
    assign quot = prod[PROD_W-1:ANG_SHIFT];

    // Offset by the minimum width and clamp at the maximum.
    assign o_width = (quot > QUOT_W'(W_MAX - W_MIN)) ? WIDTH_W'(W_MAX)
                                                    : WIDTH_W'(quot) + WIDTH_W'(W_MIN);
endmodule

@@ design/slp_slew.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter step unit
// Moves a live width one rate-limited step toward its target.
// ----------------------------------------------------------------------------
module slp_slew (
    input  slp_pkg::t_width i_now,
    input  slp_pkg::t_width i_goal,
    output slp_pkg::t_width o_next
);
    import slp_pkg::*;

    logic              above;
    t_width            gap;
    logic [STEP_W-1:0] step;

    // Distance between live and target width.
    assign above = i_now > i_goal;
    assign gap   = above ? (i_now - i_goal) : (i_goal - i_now);

    // Larger gaps take larger steps.
    always_comb begin
        priority if (gap > WIDTH_W'(GAP_BIG)) begin
            step = STEP_W'(STEP_BIG);
        end else if (gap > WIDTH_W'(GAP_MID)) begin
            step = STEP_W'(STEP_MID);
        end else begin
            step = STEP_W'(STEP_MIN);
        end
    end

    // No step overshoots, and equal widths stay put.
    always_comb begin
        if (i_now == i_goal) begin
            o_next = i_now;
        end else if (above) begin
            o_next = i_now - WIDTH_W'(step);
        end else begin
            o_next = i_now + WIDTH_W'(step);
        end
    end
endmodule

@@ design/servo_pwm_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// Servo pulse-width slew limiter
// Eight-channel target and live width registers with a rate-limited step.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side does not stall.
// An accepted item waits in the input register; the compute stage then
// updates the addressed channel and loads the result register. The
// read-modify-write of the channel registers in the compute stage sets this
// rate, and back-to-back items on the same channel see each other's updates.
// Ready drops only while both stages hold items and the result is not taken.
// The settle mask may be written at any time the block holds no items.
module servo_pwm_slew_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    slp_item_if.sink                      i_item,
    slp_result_if.source                  o_result,
    input  logic                          i_cfg_we,
    input  logic [slp_pkg::MASK_W-1:0]    i_cfg_wdata
);
    import slp_pkg::*;

    // Input stage.
    logic                      r_in_valid;
    logic [MODE_W-1:0]         r_in_mode;
    logic [CHAN_W-1:0]         r_in_channel;
    logic [ANGLE_W-1:0]        r_in_angle;

    // Channel registers and the settle mask.
    t_width                    r_live [CHANNELS];
    t_width                    r_goal [CHANNELS];
    t_width                    n_live [CHANNELS];
    t_width                    n_goal [CHANNELS];
    logic [MASK_W-1:0]         r_mask;

    // Result register.
    logic                      r_out_valid;
    t_width                    r_out_now;
    t_width                    r_out_goal;
    logic                      r_out_settled;
    logic                      r_out_rejected;

    logic                      advance;
    logic                      ch_ok;
    logic [CH_IDX_W-1:0]       idx;
    logic                      neg;
    t_width                    map_width;
    t_width                    slew_width;
    t_width                    rd_live;
    t_width                    rd_goal;
    logic                      settled;
    logic                      rejected;

    // Handshake: the compute stage moves when the result register is free or emptying.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_mode    <= i_item.mode;
            r_in_channel <= i_item.channel;
            r_in_angle   <= i_item.angle_deg;
        end
    end

    // Decode of the held item.
    assign ch_ok   = 32'(r_in_channel) < CHANNELS;
    assign idx     = CH_IDX_W'(r_in_channel);
    assign neg     = r_in_angle[ANGLE_W-1];
    assign rd_live = r_live[idx];
    assign rd_goal = r_goal[idx];

    slp_angle_map u_angle_map (
        .i_angle (r_in_angle[ANG_MAG_W-1:0]),
        .o_width (map_width)
    );

    slp_slew u_slew (
        .i_now  (rd_live),
        .i_goal (rd_goal),
        .o_next (slew_width)
    );

    // Next channel register contents after the held item.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_live[c] = r_live[c];
            n_goal[c] = r_goal[c];
        end
        if (ch_ok) begin
            unique case (r_in_mode)
                MODE_INIT: begin
                    if (!neg) begin
                        n_live[idx] = map_width;
                        n_goal[idx] = map_width;
                    end
                end
                MODE_SET: begin
                    if (!neg) begin
                        n_goal[idx] = map_width;
                    end
                end
                MODE_STEP: begin
                    n_live[idx] = slew_width;
                end
                default: begin
                end
            endcase
        end
    end

    // A negative angle is refused only by the loading operations.
    assign rejected = ch_ok && neg &&
                      ((r_in_mode == MODE_INIT) || (r_in_mode == MODE_SET));

    // Every masked channel must match its target after this item.
    always_comb begin
        settled = 1'b1;
        for (int c = 0; c < MASK_N; c++) begin
            if (r_mask[c] && (n_live[c] != n_goal[c])) begin
                settled = 1'b0;
            end
        end
    end

    // Channel registers update as the item leaves the compute stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_live[c] <= '0;
                r_goal[c] <= '0;
            end
            r_goal[0] <= WIDTH_W'(W_MIN);
        end else if (advance) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_live[c] <= n_live[c];
                r_goal[c] <= n_goal[c];
            end
        end
    end

    // Settle mask register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_now      <= ch_ok ? n_live[idx] : '0;
            r_out_goal     <= ch_ok ? n_goal[idx] : '0;
            r_out_settled  <= settled;
            r_out_rejected <= rejected;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.width_now      = r_out_now;
    assign o_result.width_goal     = r_out_goal;
    assign o_result.all_settled    = r_out_settled;
    assign o_result.angle_rejected = r_out_rejected;
endmodule

@@ design/slp_checker.sv @@
// ----------------------------------------------------------------------------
// Servo slew limiter checker
// Port-level properties of the slew limiter, bound to the top level.
// ----------------------------------------------------------------------------
module slp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [slp_pkg::WIDTH_W-1:0]   i_width_now,
    input logic [slp_pkg::WIDTH_W-1:0]   i_width_goal,
    input logic                          i_all_settled,
    input logic                          i_angle_rejected
);
    import slp_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Input back-pressure only comes from a stalled result.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_width_now) && $stable(i_width_goal) &&
             $stable(i_all_settled) && $stable(i_angle_rejected)))
        else $error("stalled result changed");

    // Reported widths never exceed the clamp.
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_width_now <= WIDTH_W'(W_MAX)) &&
                         (i_width_goal <= WIDTH_W'(W_MAX))))
        else $error("width beyond clamp");
endmodule

bind servo_pwm_slew_limiter slp_checker u_slp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_width_now      (o_result.width_now),
    .i_width_goal     (o_result.width_goal),
    .i_all_settled    (o_result.all_settled),
    .i_angle_rejected (o_result.angle_rejected)
);

@@ tb/sv/tb_servo_pwm_slew_limiter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo pulse-width slew limiter testbench
// Drives command items with random gaps and result stalls, predicts every
// result from a behavioral copy of the channel registers, and compares each
// result field by field. A short directed table comes first, followed by
// random phases under several settle masks.
// ----------------------------------------------------------------------------
module tb_servo_pwm_slew_limiter;
    import slp_pkg::*;

    // Mode code 3 has no operation behind it.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int TAIL_CYCLES = 6;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [CHAN_W-1:0]         channel;
        logic signed [ANGLE_W-1:0] angle;
    } t_servo_cmd;

    typedef struct packed {
        t_width now;
        t_width goal;
        logic   settled;
        logic   rejected;
    } t_servo_result;

    typedef struct packed {
        t_servo_cmd    cmd;
        logic          typed;
        t_servo_result want;
    } t_servo_row;

    // Directed rows start from reset with the reset mask. Rows with typed
    // results can be read off directly; the rest go through the predictor.
    localparam int DIR_ROWS = 24;
    localparam t_servo_row DIRECTED_ROWS [DIR_ROWS] = '{
        // Unused mode right after reset reports the reset widths.
        '{'{MODE_NONE, 3'd0, 11'sd0},    1'b1, '{11'd0,    11'd250, 1'b0, 1'b0}},
        // Step with equal widths and the most negative angle is not rejected.
        '{'{MODE_STEP, 3'd1, 11'sh400},  1'b1, '{11'd0,    11'd0,   1'b0, 1'b0}},
        '{'{MODE_STEP, 3'd0, 11'sd0},    1'b1, '{11'd10,   11'd250, 1'b0, 1'b0}},
        '{'{MODE_INIT, 3'd0, 11'sd0},    1'b1, '{11'd250,  11'd250, 1'b1, 1'b0}},
        // Negative angles in init and set change nothing.
        '{'{MODE_INIT, 3'd1, 11'sh7FF},  1'b1, '{11'd0,    11'd0,   1'b1, 1'b1}},
        '{'{MODE_SET,  3'd1, 11'sh400},  1'b1, '{11'd0,    11'd0,   1'b1, 1'b1}},
        // Largest angle clamps to the top width.
        '{'{MODE_INIT, 3'd2, 11'sd1023}, 1'b1, '{11'd1250, 11'd1250, 1'b1, 1'b0}},
        '{'{MODE_SET,  3'd2, 11'sd0},    1'b1, '{11'd1250, 11'd250, 1'b0, 1'b0}},
        '{'{MODE_STEP, 3'd2, 11'sd0},    1'b0, '0},
        '{'{MODE_STEP, 3'd2, 11'sh7FB},  1'b0, '0},
        '{'{MODE_NONE, 3'd2, 11'sh7FF},  1'b0, '0},
        // Gap of exactly 45 takes the middle step.
        '{'{MODE_INIT, 3'd3, 11'sd1},    1'b0, '0},
        '{'{MODE_SET,  3'd3, 11'sd17},   1'b0, '0},
        '{'{MODE_STEP, 3'd3, 11'sd0},    1'b0, '0},
        // Gap of exactly 25 takes the unit step.
        '{'{MODE_INIT, 3'd4, 11'sd0},    1'b0, '0},
        '{'{MODE_SET,  3'd4, 11'sd9},    1'b0, '0},
        '{'{MODE_STEP, 3'd4, 11'sd0},    1'b0, '0},
        // Gap of 47 takes a large step and then a middle one.
        '{'{MODE_INIT, 3'd5, 11'sd0},    1'b0, '0},
        '{'{MODE_SET,  3'd5, 11'sd17},   1'b0, '0},
        '{'{MODE_STEP, 3'd5, 11'sd0},    1'b0, '0},
        '{'{MODE_STEP, 3'd5, 11'sd0},    1'b0, '0},
        // Angles just over and exactly at the clamp point.
        '{'{MODE_SET,  3'd7, 11'sd361},  1'b0, '0},
        '{'{MODE_SET,  3'd6, 11'sd360},  1'b0, '0},
        '{'{MODE_STEP, 3'd7, 11'sd0},    1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MASK_W-1:0] i_cfg_wdata;

    slp_item_if   item_ch ();
    slp_result_if result_ch ();

    servo_pwm_slew_limiter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch),
        .o_result    (result_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Behavioral copy of the channel registers and the settle mask.
    t_width            goal_model [CHANNELS];
    t_width            live_model [CHANNELS];
    logic [MASK_W-1:0] mask_model;

    t_servo_result pending_results [$];
    int  error_count;
    int  item_count;
    int  result_count;
    int  settled_count;
    int  reject_count;
    int  mask_writes;
    bit  src_calm;
    bit  snk_calm;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Applies one item to the channel model and returns its result.
    function automatic t_servo_result predict_servo(t_servo_cmd cmd);
        t_servo_result r;
        int w;
        int gap;
        int step;
        r = '0;
        if (cmd.channel < CHANNELS) begin
            if (cmd.mode == MODE_INIT || cmd.mode == MODE_SET) begin
                if (cmd.angle[ANGLE_W-1]) begin
                    r.rejected = 1'b1;
                end else begin
                    w = (int'(cmd.angle[ANGLE_W-2:0]) * 25) / 9 + W_MIN;
                    if (w > W_MAX) w = W_MAX;
                    goal_model[cmd.channel] = t_width'(w);
                    if (cmd.mode == MODE_INIT) live_model[cmd.channel] = t_width'(w);
                end
            end else if (cmd.mode == MODE_STEP) begin
                if (live_model[cmd.channel] != goal_model[cmd.channel]) begin
                    gap = int'(live_model[cmd.channel]) - int'(goal_model[cmd.channel]);
                    if (gap < 0) gap = -gap;
                    if (gap > GAP_BIG) step = STEP_BIG;
                    else if (gap > GAP_MID) step = STEP_MID;
                    else step = STEP_MIN;
                    if (live_model[cmd.channel] > goal_model[cmd.channel])
                        live_model[cmd.channel] = live_model[cmd.channel] - t_width'(step);
                    else
                        live_model[cmd.channel] = live_model[cmd.channel] + t_width'(step);
                end
            end
            r.now  = live_model[cmd.channel];
            r.goal = goal_model[cmd.channel];
        end
        r.settled = 1'b1;
        for (int c = 0; c < MASK_N; c++) begin
            if (mask_model[c] && live_model[c] != goal_model[c]) r.settled = 1'b0;
        end
        return r;
    endfunction

    // Random item: mostly steps and valid targets, some rejects and unused modes.
    function automatic t_servo_cmd random_cmd();
        t_servo_cmd cmd;
        int pick;
        pick = $urandom_range(0, 99);
        cmd.channel = CHAN_W'($urandom_range(0, 7));
        cmd.angle   = ANGLE_W'($urandom_range(0, 2047));
        if (pick < 45) begin
            cmd.mode = MODE_STEP;
        end else if (pick < 85) begin
            cmd.mode = (pick < 70) ? MODE_SET : MODE_INIT;
            // Small angles keep targets close together so the step thresholds are hit.
            if ($urandom_range(0, 1) == 0)
                cmd.angle = ANGLE_W'($urandom_range(0, 40));
            else
                cmd.angle = ANGLE_W'($urandom_range(0, 1023));
        end else if (pick < 93) begin
            cmd.mode  = ($urandom_range(0, 1) == 0) ? MODE_INIT : MODE_SET;
            cmd.angle = ANGLE_W'($urandom_range(1024, 2047));
        end else begin
            cmd.mode = MODE_NONE;
        end
        return cmd;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        error_count++;
        $display("MISMATCH result %0d %s: got %0d expected %0d",
                 result_count, field, got, want);
    endtask

    // Sends one item; called and returns at a falling edge.
    task automatic send_cmd(t_servo_cmd cmd, logic typed, t_servo_result typed_want);
        int gap;
        t_servo_result predicted;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= cmd.mode;
        item_ch.channel   <= cmd.channel;
        item_ch.angle_deg <= cmd.angle;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        predicted = predict_servo(cmd);
        pending_results.push_back(typed ? typed_want : predicted);
        item_count++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every pending result has been taken.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes the settle mask while the block is idle.
    task automatic write_mask(logic [MASK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mask_model = value;
        mask_writes++;
    endtask

    // Result side: random stall per item, then check against the oldest prediction.
    initial begin
        int stall;
        t_servo_result want;
        result_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
            if (pending_results.size() == 0) begin
                report_mismatch("result with no pending item",
                                int'(result_ch.width_now), 0);
            end else begin
                want = pending_results.pop_front();
                if (result_ch.width_now !== want.now)
                    report_mismatch("width_now", int'(result_ch.width_now),
                                    int'(want.now));
                if (result_ch.width_goal !== want.goal)
                    report_mismatch("width_goal", int'(result_ch.width_goal),
                                    int'(want.goal));
                if (result_ch.all_settled !== want.settled)
                    report_mismatch("all_settled", int'(result_ch.all_settled),
                                    int'(want.settled));
                if (result_ch.angle_rejected !== want.rejected)
                    report_mismatch("angle_rejected", int'(result_ch.angle_rejected),
                                    int'(want.rejected));
            end
            if (result_ch.all_settled === 1'b1) settled_count++;
            if (result_ch.angle_rejected === 1'b1) reject_count++;
            result_count++;
            @(negedge i_clk);
        end
    end

    // Main sequence: reset, directed table, then random phases per mask.
    initial begin
        logic [MASK_W-1:0] phase_mask;
        error_count   = 0;
        item_count    = 0;
        result_count  = 0;
        settled_count = 0;
        reject_count  = 0;
        mask_writes   = 0;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_INIT;
        item_ch.channel   = '0;
        item_ch.angle_deg = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            goal_model[c] = '0;
            live_model[c] = '0;
        end
        goal_model[0] = t_width'(W_MIN);
        mask_model    = MASK_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table under the reset mask.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        drain_results();

        // Random phases, each under its own mask and idle profile.
        for (int p = 0; p < PHASES; p++) begin
            unique case (p)
                0: begin
                    phase_mask = 8'hFF;
                end
                1: begin
                    phase_mask = 8'h00;
                end
                2: begin
                    phase_mask = 8'h01;
                end
                3: begin
                    phase_mask = 8'h80;
                end
                4: begin
                    phase_mask = MASK_RESET;
                end
                default: begin
                    phase_mask = MASK_W'($urandom_range(0, 255));
                end
            endcase
            src_calm = (p % 4 == 1) || (p % 4 == 3);
            snk_calm = (p % 4 == 2) || (p % 4 == 3);
            write_mask(phase_mask);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_cmd(random_cmd(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d items and %0d results under %0d mask settings.",
                 item_count, result_count, mask_writes + 1);
        $display("Results with all channels settled: %0d, with a rejected angle: %0d.",
                 settled_count, reject_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/slp_pkg.sv
design/slp_item_if.sv
design/slp_result_if.sv
design/slp_angle_map.sv
design/slp_slew.sv
design/servo_pwm_slew_limiter.sv
design/slp_checker.sv
tb/sv/tb_servo_pwm_slew_limiter.sv
